// ----- rtl/idm_pkg.sv -----
// Shared constants, types and command/status structures for the image distance metrics block.
package idm_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int MAX_PAIRS  = 16777216;
  localparam int FRAC_BITS  = 8;
  localparam int FIELD_W    = 16;

  localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
  localparam int AD_W      = PIXEL_BITS + 1;
  localparam int SQR_W     = 2 * PIXEL_BITS + 1;
  localparam int ABS_SUM_W = AD_W + CNT_W - 1;
  localparam int SQ_SUM_W  = SQR_W + CNT_W - 1;
  localparam int DVD_W     = SQ_SUM_W + 2 * FRAC_BITS;
  localparam int QUO_W     = SQR_W + 2 * FRAC_BITS;
  localparam int STEP_W    = $clog2(DVD_W + 1);
  localparam int SQRT_TOP  = ((QUO_W - 1) / 2) * 2;

  localparam int METRIC_W    = 24;
  localparam int IN_TDATA_W  = 2 * FIELD_W;
  localparam int OUT_FIELD_W = METRIC_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [METRIC_W-1:0] METRIC_MAX = '1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;
  localparam int MODE_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_METRIC_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGAINST_ZERO = 2'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_MEAN = 2'd0,
    MODE_RMS  = 2'd1,
    MODE_MAX  = 2'd2,
    MODE_NONE = 2'd3
  } metric_mode_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_DIV,
    ST_SQRT,
    ST_FINISH
  } idm_state_t;

  typedef struct packed {
    logic         take;
    logic         against_zero;
    logic         clear_acc;
    logic         div_start;
    logic         sqrt_start;
    logic         load_result;
    metric_mode_t result_sel;
  } idm_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } idm_calc_stat_t;

endpackage

// ----- rtl/idm_accum.sv -----
// Accumulation datapath: difference, absolute value, square and the running sums, maximum and count.
module idm_accum (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [idm_pkg::FIELD_W-1:0]      pixel_a,
  input  logic [idm_pkg::FIELD_W-1:0]      pixel_b,
  input  idm_pkg::idm_cmd_t                cmd,
  output logic                             pipe_busy,
  output logic [idm_pkg::ABS_SUM_W-1:0]    abs_sum,
  output logic [idm_pkg::SQ_SUM_W-1:0]     square_sum,
  output logic [idm_pkg::AD_W-1:0]         max_abs,
  output logic [idm_pkg::CNT_W-1:0]        element_count
);
  import idm_pkg::*;

  logic [PIXEL_BITS-1:0] pa;
  logic [PIXEL_BITS-1:0] pb;
  logic [AD_W-1:0]       diff;
  logic [AD_W-1:0]       ad;
  logic                  count_ok;
  logic [2*AD_W-1:0]     prod;

  logic                  s1_vld;
  logic [AD_W-1:0]       s1_ad;
  logic                  s2_vld;
  logic [AD_W-1:0]       s2_ad;
  logic [SQR_W-1:0]      s2_sq;

  // Pixels are the low PIXEL_BITS bits of each field, taken as signed.
  always_comb begin
    pa       = pixel_a[PIXEL_BITS-1:0];
    pb       = cmd.against_zero ? '0 : pixel_b[PIXEL_BITS-1:0];
    diff     = {pa[PIXEL_BITS-1], pa} - {pb[PIXEL_BITS-1], pb};
    ad       = diff[AD_W-1] ? (~diff + 1'b1) : diff;
    count_ok = element_count < CNT_W'(MAX_PAIRS);
    prod     = s1_ad * s1_ad;
  end

  assign pipe_busy = s1_vld || s2_vld;

  always_ff @(posedge clk) begin
    s1_ad <= ad;
    s2_ad <= s1_ad;
    s2_sq <= prod[SQR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld        <= 1'b0;
      s2_vld        <= 1'b0;
      abs_sum       <= '0;
      square_sum    <= '0;
      max_abs       <= '0;
      element_count <= '0;
    end else begin
      // A pair beyond the maximum count travels down the pipe as a bubble.
      s1_vld <= cmd.take && count_ok;
      s2_vld <= s1_vld;
      if (cmd.clear_acc) begin
        abs_sum       <= '0;
        square_sum    <= '0;
        max_abs       <= '0;
        element_count <= '0;
      end else begin
        if (cmd.take && count_ok) begin
          element_count <= element_count + 1'b1;
        end
        if (s2_vld) begin
          abs_sum    <= abs_sum + ABS_SUM_W'(s2_ad);
          square_sum <= square_sum + SQ_SUM_W'(s2_sq);
          if (s2_ad > max_abs) begin
            max_abs <= s2_ad;
          end
        end
      end
    end
  end

`ifndef SYNTH
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    element_count <= CNT_W'(MAX_PAIRS))
    else $error("pair count exceeds the maximum");

  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_acc |=> element_count == '0)
    else $error("count not cleared after a result");
`endif

endmodule

// ----- rtl/idm_calc.sv -----
// Result datapath: bit-serial divider, bit-pair square root, metric selection and output register.
module idm_calc (
  input  logic                              clk,
  input  logic                              rst,
  input  idm_pkg::idm_cmd_t                 cmd,
  input  logic [idm_pkg::ABS_SUM_W-1:0]     abs_sum,
  input  logic [idm_pkg::SQ_SUM_W-1:0]      square_sum,
  input  logic [idm_pkg::AD_W-1:0]          max_abs,
  input  logic [idm_pkg::CNT_W-1:0]         element_count,
  output idm_pkg::idm_calc_stat_t           stat,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [idm_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import idm_pkg::*;

  logic [DVD_W-1:0]  dvd;
  logic [CNT_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] div_left;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_sub;
  logic              fits;

  logic [QUO_W-1:0]  sx;
  logic [QUO_W-1:0]  root;
  logic [QUO_W-1:0]  sbit;
  logic [QUO_W:0]    sum;
  logic              takes;

  logic [QUO_W-1:0]    wide;
  logic [METRIC_W-1:0] metric;
  logic [METRIC_W-1:0] out_metric;
  logic [CNT_W-1:0]    out_count;
  logic                div_busy;
  logic                sqrt_busy;

  assign div_busy  = div_left != '0;
  assign sqrt_busy = |sbit;

  always_comb begin
    stat.div_busy  = div_busy;
    stat.sqrt_busy = sqrt_busy;
    stat.out_free  = !m_tvalid || m_tready;
  end

  // Restoring division: one quotient bit per cycle, most significant first.
  always_comb begin
    trial     = {rem, dvd[DVD_W-1]};
    fits      = trial >= {1'b0, element_count};
    trial_sub = trial - {1'b0, element_count};
    sum       = {1'b0, root} + {1'b0, sbit};
    takes     = {1'b0, sx} >= sum;
  end

  always_comb begin
    case (cmd.result_sel)
      MODE_MEAN: wide = quo;
      MODE_RMS:  wide = root;
      MODE_MAX:  wide = QUO_W'({max_abs, {FRAC_BITS{1'b0}}});
      default:   wide = '0;
    endcase
    if (element_count == '0 && (cmd.result_sel == MODE_MEAN || cmd.result_sel == MODE_RMS)) begin
      wide = '0;
    end
    metric = (wide > QUO_W'(METRIC_MAX)) ? METRIC_MAX : wide[METRIC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      if (cmd.result_sel == MODE_RMS) begin
        dvd <= {square_sum, {(2*FRAC_BITS){1'b0}}};
      end else begin
        dvd <= DVD_W'({abs_sum, {FRAC_BITS{1'b0}}});
      end
      rem <= '0;
      quo <= '0;
    end else if (div_busy) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      rem <= fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      quo <= {quo[QUO_W-2:0], fits};
    end

    if (cmd.sqrt_start) begin
      sx   <= quo;
      root <= '0;
    end else if (sqrt_busy) begin
      if (takes) begin
        sx   <= sx - sum[QUO_W-1:0];
        root <= (root >> 1) + sbit;
      end else begin
        root <= root >> 1;
      end
    end

    if (cmd.load_result) begin
      out_metric <= metric;
      out_count  <= element_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_left <= '0;
      sbit     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.div_start) begin
        div_left <= STEP_W'(DVD_W);
      end else if (div_busy) begin
        div_left <= div_left - 1'b1;
      end

      if (cmd.sqrt_start) begin
        sbit <= QUO_W'(1) << SQRT_TOP;
      end else if (sqrt_busy) begin
        sbit <= sbit >> 2;
      end

      if (cmd.load_result) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_count, out_metric};

`ifndef SYNTH
  a_sqrt_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.sqrt_start |-> !div_busy)
    else $error("square root started while the divider is busy");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> !div_busy && !sqrt_busy)
    else $error("result loaded while a calculation is running");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |=> m_tvalid)
    else $error("loaded result not presented");
`endif

endmodule

// ----- rtl/idm_ctrl.sv -----
// Controller: configuration registers and the state machine that sequences accumulation and result.
module idm_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic                              s_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [idm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [idm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              pipe_busy,
  input  idm_pkg::idm_calc_stat_t           calc_stat,
  output idm_pkg::idm_cmd_t                 cmd
);
  import idm_pkg::*;

  idm_state_t   state;
  idm_state_t   state_next;
  metric_mode_t metric_mode;
  logic         against_zero;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_ACCUM;
      metric_mode  <= MODE_MEAN;
      against_zero <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_METRIC_MODE:  metric_mode  <= metric_mode_t'(cfg_data[MODE_W-1:0]);
          CFG_AGAINST_ZERO: against_zero <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    state_next       = state;
    s_tready         = state == ST_ACCUM;
    cmd.take         = s_tvalid && s_tready;
    cmd.against_zero = against_zero;
    cmd.clear_acc    = 1'b0;
    cmd.div_start    = 1'b0;
    cmd.sqrt_start   = 1'b0;
    cmd.load_result  = 1'b0;
    cmd.result_sel   = metric_mode;
    case (state)
      ST_ACCUM: begin
        if (s_tvalid && s_tlast) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The sums are final once the last pair has left the pipeline.
        if (!pipe_busy) begin
          if (metric_mode == MODE_MEAN || metric_mode == MODE_RMS) begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_DIV: begin
        if (!calc_stat.div_busy) begin
          if (metric_mode == MODE_RMS) begin
            cmd.sqrt_start = 1'b1;
            state_next     = ST_SQRT;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SQRT: begin
        if (!calc_stat.sqrt_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (calc_stat.out_free) begin
          cmd.load_result = 1'b1;
          cmd.clear_acc   = 1'b1;
          state_next      = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

endmodule

// ----- rtl/image_distance_metrics.sv -----
// From the transfer of the last pair to the result: the maximum metric is loaded once the pipeline has drained,
// the mean uses the 73-step serial divider and the RMS uses the divider, then the 25-step root.
// Throughput: one pixel pair per cycle within an image; the input stalls from the last pair
// until the result is loaded into the output register, which then waits for its transfer.
// Reset (rst, synchronous, active high) clears the sums, maximum, count and both registers.
module image_distance_metrics (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [idm_pkg::IN_TDATA_W-1:0]    s_tdata,   // pixel_a, pixel_b
  input  logic                              s_tlast,   // last_pair
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [idm_pkg::OUT_TDATA_W-1:0]   m_tdata,   // metric_value, pair_count, zero pad
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [idm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [idm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import idm_pkg::*;

  idm_cmd_t            cmd;
  idm_calc_stat_t      calc_stat;
  logic                pipe_busy;
  logic [ABS_SUM_W-1:0] abs_sum;
  logic [SQ_SUM_W-1:0]  square_sum;
  logic [AD_W-1:0]      max_abs;
  logic [CNT_W-1:0]     element_count;

  idm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pipe_busy (pipe_busy),
    .calc_stat (calc_stat),
    .cmd       (cmd)
  );

  idm_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .pixel_a       (s_tdata[FIELD_W-1:0]),
    .pixel_b       (s_tdata[2*FIELD_W-1:FIELD_W]),
    .cmd           (cmd),
    .pipe_busy     (pipe_busy),
    .abs_sum       (abs_sum),
    .square_sum    (square_sum),
    .max_abs       (max_abs),
    .element_count (element_count)
  );

  idm_calc u_calc (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .abs_sum       (abs_sum),
    .square_sum    (square_sum),
    .max_abs       (max_abs),
    .element_count (element_count),
    .stat          (calc_stat),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata)
  );

endmodule
